/* design/escape_pattern_frame_stuffer_defines.svh */
// Assertion macros for the escape pattern frame stuffer checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ESCAPE_PATTERN_FRAME_STUFFER_DEFINES_SVH
`define ESCAPE_PATTERN_FRAME_STUFFER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ESF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("esf: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ESF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("esf: next-cycle check failed");

`endif

/* design/esf_pkg.sv */
// Shared types and constants of the escape pattern frame stuffer.
// Used by the front, the command queue, the back and the top level.
package esf_pkg;

  // Register widths and reset values of the configuration port.
  localparam int unsigned FlagRegW  = 8;
  localparam int unsigned EscRegW   = 5;
  localparam int unsigned CfgDataW  = 8;
  localparam logic [FlagRegW-1:0] FlagReset = 8'd126;
  localparam logic [EscRegW-1:0]  EscReset  = 5'd27;

  // At most this many output bits per input word.
  localparam int unsigned MaxResults = 21;

  typedef enum logic [0:0] {
    CFG_FLAG   = 1'b0,
    CFG_ESCAPE = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_OPEN     = 3'd0,
    CMD_FLAG_ESC = 3'd1,
    CMD_ESC_ESC  = 3'd2,
    CMD_COPY     = 3'd3,
    CMD_CLOSE    = 3'd4
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    logic      bit_val;
    logic      item_last;
  } cmd_t;

endpackage

/* design/esf_front.sv */
// Front end: accepts input words, keeps the lookahead window and classifies
// each greedy decision into a command for the back end. Uses esf_pkg.
module esf_front #(
  parameter int unsigned FLAG_BITS   = 8,
  parameter int unsigned ESCAPE_BITS = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   in_bit_i,
  input  logic                   frame_last_i,
  input  logic [FLAG_BITS-1:0]   flag_i,
  input  logic [ESCAPE_BITS-1:0] esc_i,
  output logic                   push_o,
  output esf_pkg::cmd_t          cmd_o,
  input  logic                   full_i
);

  localparam int unsigned WinBits = (FLAG_BITS > ESCAPE_BITS) ? FLAG_BITS : ESCAPE_BITS;
  localparam int unsigned CntW    = $clog2(WinBits + 1);

  typedef enum logic {
    FR_IDLE,
    FR_WORK
  } fr_state_e;

  fr_state_e          state_q, state_d;
  logic [WinBits-1:0] win_q, win_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               open_q, open_d;
  logic               need_open_q, need_open_d;
  logic               last_q, last_d;

  logic [WinBits-1:0] head_f, head_e, head_1, keep_mask;
  logic               flag_hit, esc_hit, copy_bit, open_is_last;
  logic [CntW-1:0]    dec_len, rem;
  esf_pkg::cmd_kind_e dec_kind;

  // Head of the window: oldest bits sit just below the fill count.
  always_comb begin
    head_f   = win_q >> (cnt_q - CntW'(FLAG_BITS));
    head_e   = win_q >> (cnt_q - CntW'(ESCAPE_BITS));
    head_1   = win_q >> (cnt_q - CntW'(1));
    copy_bit = head_1[0];
    flag_hit = (cnt_q >= CntW'(FLAG_BITS)) && (head_f[FLAG_BITS-1:0] == flag_i);
    esc_hit  = (cnt_q >= CntW'(ESCAPE_BITS)) && (head_e[ESCAPE_BITS-1:0] == esc_i);
    priority if (flag_hit) begin
      dec_kind = esf_pkg::CMD_FLAG_ESC;
      dec_len  = CntW'(FLAG_BITS);
    end else if (esc_hit) begin
      dec_kind = esf_pkg::CMD_ESC_ESC;
      dec_len  = CntW'(ESCAPE_BITS);
    end else begin
      dec_kind = esf_pkg::CMD_COPY;
      dec_len  = CntW'(1);
    end
    rem = cnt_q - dec_len;
    for (int i = 0; i < WinBits; i++) begin
      keep_mask[i] = (i < rem);
    end
  end

  always_comb begin
    state_d      = state_q;
    win_d        = win_q;
    cnt_d        = cnt_q;
    open_d       = open_q;
    need_open_d  = need_open_q;
    last_d       = last_q;
    push_o       = 1'b0;
    cmd_o        = '{kind: dec_kind, bit_val: copy_bit, item_last: 1'b0};
    open_is_last = !last_q && (cnt_q != CntW'(WinBits));
    unique case (state_q)
      FR_IDLE: begin
        if (in_valid_i) begin
          win_d       = {win_q[WinBits-2:0], in_bit_i};
          cnt_d       = cnt_q + CntW'(1);
          need_open_d = !open_q;
          open_d      = 1'b1;
          last_d      = frame_last_i;
          state_d     = FR_WORK;
        end
      end
      FR_WORK: begin
        if (!full_i) begin
          priority if (need_open_q) begin
            push_o         = 1'b1;
            cmd_o.kind     = esf_pkg::CMD_OPEN;
            cmd_o.item_last = open_is_last;
            need_open_d    = 1'b0;
            if (open_is_last) begin
              state_d = FR_IDLE;
            end
          end else if (last_q && (cnt_q != '0)) begin
            // flush one decision per cycle while the queue is not full
            push_o = 1'b1;
            win_d  = win_q & keep_mask;
            cnt_d  = rem;
          end else if (last_q) begin
            push_o          = 1'b1;
            cmd_o.kind      = esf_pkg::CMD_CLOSE;
            cmd_o.item_last = 1'b1;
            win_d           = '0;
            cnt_d           = '0;
            open_d          = 1'b0;
            state_d         = FR_IDLE;
          end else if (cnt_q == CntW'(WinBits)) begin
            push_o          = 1'b1;
            cmd_o.item_last = 1'b1;
            win_d           = win_q & keep_mask;
            cnt_d           = rem;
            state_d         = FR_IDLE;
          end else begin
            state_d = FR_IDLE;
          end
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == FR_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FR_IDLE;
      win_q       <= '0;
      cnt_q       <= '0;
      open_q      <= 1'b0;
      need_open_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      cnt_q       <= cnt_d;
      open_q      <= open_d;
      need_open_q <= need_open_d;
      last_q      <= last_d;
    end
  end

endmodule

/* design/esf_cmd_fifo.sv */
// Four-entry command queue between the front and the back end.
// Holds esf_pkg::cmd_t entries in flops.
module esf_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  esf_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output esf_pkg::cmd_t data_o,
  output logic          empty_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  esf_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + (PtrW+1)'(push_i && !full_o) - (PtrW+1)'(pop_i && !empty_o);
    end
  end

endmodule

/* design/esf_back.sv */
// Back end: serializes queued commands into output bits, one per cycle while
// the output is not stalled, into a registered output word. Uses esf_pkg.
module esf_back #(
  parameter int unsigned FLAG_BITS   = 8,
  parameter int unsigned ESCAPE_BITS = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [FLAG_BITS-1:0]   flag_i,
  input  logic [ESCAPE_BITS-1:0] esc_i,
  input  esf_pkg::cmd_t          cmd_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   out_bit_o,
  output logic                   run_last_o,
  output logic                   frame_end_o
);

  localparam int unsigned PatW  = (FLAG_BITS > ESCAPE_BITS) ? FLAG_BITS : ESCAPE_BITS;
  localparam int unsigned IdxW  = $clog2(PatW);
  localparam int unsigned RcntW = $clog2(esf_pkg::MaxResults + 1);

  logic            busy_q, busy_d;
  esf_pkg::cmd_t   cmd_q, cmd_d;
  logic            seg_q, seg_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [RcntW-1:0] rcnt_q, rcnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_bit_q, out_bit_d;
  logic            run_last_q, run_last_d;
  logic            frame_end_q, frame_end_d;

  logic                   is_flag_seg, is_copy, two_seg;
  logic                   adv, step, emit, load, end_seg, end_cmd, cur_bit;
  logic [IdxW-1:0]        len_m1, pos;
  logic [FLAG_BITS-1:0]   flag_sh;
  logic [ESCAPE_BITS-1:0] esc_sh;

  always_comb begin
    is_flag_seg = 1'b0;
    is_copy     = 1'b0;
    two_seg     = 1'b0;
    unique case (cmd_q.kind)
      esf_pkg::CMD_OPEN,
      esf_pkg::CMD_CLOSE:    is_flag_seg = 1'b1;
      esf_pkg::CMD_FLAG_ESC: begin
        is_flag_seg = seg_q;
        two_seg     = 1'b1;
      end
      esf_pkg::CMD_ESC_ESC:  two_seg = 1'b1;
      esf_pkg::CMD_COPY:     is_copy = 1'b1;
      default:               is_copy = 1'b1;
    endcase
    if (is_copy) begin
      len_m1 = '0;
    end else if (is_flag_seg) begin
      len_m1 = IdxW'(FLAG_BITS - 1);
    end else begin
      len_m1 = IdxW'(ESCAPE_BITS - 1);
    end
    // patterns go out most significant bit first
    pos     = len_m1 - idx_q;
    flag_sh = flag_i >> pos;
    esc_sh  = esc_i >> pos;
    if (is_copy) begin
      cur_bit = cmd_q.bit_val;
    end else if (is_flag_seg) begin
      cur_bit = flag_sh[0];
    end else begin
      cur_bit = esc_sh[0];
    end
    end_seg = (idx_q == len_m1);
    end_cmd = end_seg && (!two_seg || seg_q);
  end

  assign adv   = !out_valid_q || out_ready_i;
  assign step  = busy_q && adv;
  assign emit  = step && (rcnt_q < RcntW'(esf_pkg::MaxResults));
  assign load  = !empty_i && (!busy_q || (step && end_cmd));
  assign pop_o = load;

  always_comb begin
    busy_d      = busy_q;
    cmd_d       = cmd_q;
    seg_d       = seg_q;
    idx_d       = idx_q;
    rcnt_d      = rcnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_bit_d   = out_bit_q;
    run_last_d  = run_last_q;
    frame_end_d = frame_end_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_bit_d   = cur_bit;
      // drop anything past the per-word cap, marking the capped bit as last
      run_last_d  = (end_cmd && cmd_q.item_last) ||
                    (rcnt_q == RcntW'(esf_pkg::MaxResults - 1));
      frame_end_d = end_cmd && (cmd_q.kind == esf_pkg::CMD_CLOSE);
      rcnt_d      = rcnt_q + RcntW'(1);
    end
    if (step) begin
      if (end_cmd) begin
        busy_d = 1'b0;
        seg_d  = 1'b0;
        idx_d  = '0;
        if (cmd_q.item_last) begin
          rcnt_d = '0;
        end
      end else if (end_seg) begin
        seg_d = 1'b1;
        idx_d = '0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
    if (load) begin
      busy_d = 1'b1;
      cmd_d  = cmd_i;
      seg_d  = 1'b0;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      seg_q       <= 1'b0;
      idx_q       <= '0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      seg_q       <= seg_d;
      idx_q       <= idx_d;
      rcnt_q      <= rcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    out_bit_q   <= out_bit_d;
    run_last_q  <= run_last_d;
    frame_end_q <= frame_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_bit_o   = out_bit_q;
  assign run_last_o  = run_last_q;
  assign frame_end_o = frame_end_q;

endmodule

/* design/escape_pattern_frame_stuffer.sv */
// Channel | handshake                | payload
// in      | in_valid_i / in_ready_o  | in_bit_i, frame_last_i
// out     | out_valid_o / out_ready_i| out_bit_o, run_last_o, frame_end_o
// cfg     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
// The front accepts an input word, then pushes its queued commands in order
// (opening flag at the start of a frame, one greedy decision once the window
// is full, and on the last word of a frame every remaining decision and the
// closing flag), stalling on a full queue, and only then takes a new word.
// Output leaves the back-end serializer one bit per cycle unless out_ready_i
// stalls it. A four-entry command queue lets either side stall.
// Reset is asynchronous and clears control state; no clearing pass is needed.
// Top level; depends on esf_pkg, esf_front, esf_cmd_fifo and esf_back.
module escape_pattern_frame_stuffer #(
  parameter int unsigned FLAG_BITS   = 8,
  parameter int unsigned ESCAPE_BITS = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [esf_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_bit_i,
  input  logic                           frame_last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_bit_o,
  output logic                           run_last_o,
  output logic                           frame_end_o
);

  logic [esf_pkg::FlagRegW-1:0] flag_q;
  logic [esf_pkg::EscRegW-1:0]  esc_q;
  logic [FLAG_BITS-1:0]         flag_pat;
  logic [ESCAPE_BITS-1:0]       esc_pat;

  esf_pkg::cmd_t push_cmd, pop_cmd;
  logic          push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= esf_pkg::FlagReset;
      esc_q  <= esf_pkg::EscReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        esf_pkg::CFG_FLAG:   flag_q <= cfg_wdata_i[esf_pkg::FlagRegW-1:0];
        esf_pkg::CFG_ESCAPE: esc_q  <= cfg_wdata_i[esf_pkg::EscRegW-1:0];
        default: ;
      endcase
    end
  end

  // fit the register values to the pattern lengths
  if (FLAG_BITS <= esf_pkg::FlagRegW) begin : g_flag_trunc
    assign flag_pat = flag_q[FLAG_BITS-1:0];
  end else begin : g_flag_ext
    assign flag_pat = {{(FLAG_BITS - esf_pkg::FlagRegW){1'b0}}, flag_q};
  end

  if (ESCAPE_BITS <= esf_pkg::EscRegW) begin : g_esc_trunc
    assign esc_pat = esc_q[ESCAPE_BITS-1:0];
  end else begin : g_esc_ext
    assign esc_pat = {{(ESCAPE_BITS - esf_pkg::EscRegW){1'b0}}, esc_q};
  end

  esf_front #(
    .FLAG_BITS  (FLAG_BITS),
    .ESCAPE_BITS(ESCAPE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_bit_i    (in_bit_i),
    .frame_last_i(frame_last_i),
    .flag_i      (flag_pat),
    .esc_i       (esc_pat),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .full_i      (full)
  );

  esf_cmd_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .data_o (pop_cmd),
    .empty_o(empty)
  );

  esf_back #(
    .FLAG_BITS  (FLAG_BITS),
    .ESCAPE_BITS(ESCAPE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flag_i     (flag_pat),
    .esc_i      (esc_pat),
    .cmd_i      (pop_cmd),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_bit_o  (out_bit_o),
    .run_last_o (run_last_o),
    .frame_end_o(frame_end_o)
  );

endmodule

/* design/esf_port_checker.sv */
// Port-level checks for escape_pattern_frame_stuffer, bound to the top level.
// Depends on escape_pattern_frame_stuffer_defines.svh.
`include "escape_pattern_frame_stuffer_defines.svh"

module esf_port_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic out_bit_o,
  input logic run_last_o,
  input logic frame_end_o
);

  // a stalled output word holds
  `ESF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_bit_o) && $stable(run_last_o) && $stable(frame_end_o))

  // the closing flag always ends the run of its input word
  `ESF_ASSERT_SAME(a_end_is_last, out_valid_o && frame_end_o, run_last_o)

  // the front is still classifying in the cycle after each accept
  `ESF_ASSERT_NEXT(a_front_busy, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind escape_pattern_frame_stuffer esf_port_checker u_port_checker (.*);
